/* rtl/fxalu_pkg.sv */
// shared types and operation codes for the q24.8 fixed-point alu
`default_nettype none
package fxalu_pkg;

  typedef enum logic [3:0] {
    FUNC_ADD      = 4'd0,
    FUNC_SUB      = 4'd1,
    FUNC_MUL      = 4'd2,
    FUNC_DIV      = 4'd3,
    FUNC_LT       = 4'd4,
    FUNC_GT       = 4'd5,
    FUNC_LE       = 4'd6,
    FUNC_GE       = 4'd7,
    FUNC_EQ       = 4'd8,
    FUNC_NE       = 4'd9,
    FUNC_MIN      = 4'd10,
    FUNC_MAX      = 4'd11,
    FUNC_INC      = 4'd12,
    FUNC_DEC      = 4'd13,
    FUNC_FROM_INT = 4'd14,
    FUNC_TO_INT   = 4'd15
  } func_e;

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               compare_true;
    logic               divide_by_zero;
  } rsp_t;

  typedef struct packed {
    logic [31:0] res;
    logic        cmp;
    logic        dz;
    logic        is_div;
    logic        neg;
  } tag_t;

endpackage
`default_nettype wire

/* rtl/fxalu_divider.sv */
// pipelined restoring divider, one quotient bit per stage, tag carried alongside
`default_nettype none
module fxalu_divider #(
  parameter int unsigned DVD_BITS = 40,
  parameter int unsigned DVS_BITS = 32
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        valid_i,
  input  wire [DVD_BITS-1:0]         dividend_i,
  input  wire [DVS_BITS-1:0]         divisor_i,
  input  fxalu_pkg::tag_t            tag_i,
  output logic                       valid_o,
  output logic [DVD_BITS-1:0]        quotient_o,
  output fxalu_pkg::tag_t            tag_o
);
  import fxalu_pkg::*;

  logic                valid_q [DVD_BITS+1];
  logic [DVS_BITS-1:0] rem_q   [DVD_BITS+1];
  logic [DVD_BITS-1:0] dvd_q   [DVD_BITS+1];
  logic [DVS_BITS-1:0] dvs_q   [DVD_BITS+1];
  tag_t                tag_q   [DVD_BITS+1];

  logic [DVS_BITS-1:0] rem_d [DVD_BITS];
  logic [DVD_BITS-1:0] dvd_d [DVD_BITS];

  for (genvar i = 0; i < DVD_BITS; i++) begin : g_step
    logic [DVS_BITS:0] trial;
    logic [DVS_BITS:0] diff;
    always_comb begin
      trial    = {rem_q[i], dvd_q[i][DVD_BITS-1]};
      diff     = trial - {1'b0, dvs_q[i]};
      rem_d[i] = diff[DVS_BITS] ? trial[DVS_BITS-1:0] : diff[DVS_BITS-1:0];
      dvd_d[i] = {dvd_q[i][DVD_BITS-2:0], ~diff[DVS_BITS]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= DVD_BITS; i++) valid_q[i] <= 1'b0;
    end else begin
      valid_q[0] <= valid_i;
      for (int i = 0; i < DVD_BITS; i++) valid_q[i+1] <= valid_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    dvd_q[0] <= dividend_i;
    dvs_q[0] <= divisor_i;
    tag_q[0] <= tag_i;
    for (int i = 0; i < DVD_BITS; i++) begin
      rem_q[i+1] <= rem_d[i];
      dvd_q[i+1] <= dvd_d[i];
      dvs_q[i+1] <= dvs_q[i];
      tag_q[i+1] <= tag_q[i];
    end
  end

  assign valid_o    = valid_q[DVD_BITS];
  assign quotient_o = dvd_q[DVD_BITS];
  assign tag_o      = tag_q[DVD_BITS];

endmodule
`default_nettype wire

/* rtl/fixed_point_q24_8_alu_unit.sv */
// top level of the signed q24.8 fixed-point alu
// start_i passes through the stage a, stage b, divider stage and output registers to valid_o
// throughput: one transaction per cycle for every operation, busy_o stays low
// the depth is set by the divider, one quotient bit per pipeline stage
// each result shows for one cycle on rsp_o with valid_o; the receiver cannot stall
// reset clears all valid bits, payload registers are not reset
`default_nettype none
module fixed_point_q24_8_alu_unit #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned WORD_BITS     = 32
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  output logic             busy_o,
  input  fxalu_pkg::req_t  req_i,
  output logic             valid_o,
  output fxalu_pkg::rsp_t  rsp_o
);
  import fxalu_pkg::*;

  localparam int unsigned W = WORD_BITS;
  localparam int unsigned F = FRACTION_BITS;
  localparam int unsigned N = W + F;

  assign busy_o = 1'b0;

  // stage a: input register
  logic                a_valid_q;
  func_e               a_func_q;
  logic signed [W-1:0] a_op_a_q, a_op_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    a_func_q <= func_e'(req_i.func);
    a_op_a_q <= req_i.operand_a[W-1:0];
    a_op_b_q <= req_i.operand_b[W-1:0];
  end

  // stage b: simple ops, product, magnitudes
  logic [W-1:0]          mag_a, mag_b, to_int_sh;
  logic [W-1:0]          simple_res;
  logic                  simple_cmp;
  logic signed [2*W-1:0] product;

  always_comb begin
    mag_a     = a_op_a_q[W-1] ? W'(-a_op_a_q) : W'(a_op_a_q);
    mag_b     = a_op_b_q[W-1] ? W'(-a_op_b_q) : W'(a_op_b_q);
    to_int_sh = mag_a >> F;
    product   = a_op_a_q * a_op_b_q;
    simple_res = '0;
    simple_cmp = 1'b0;
    case (a_func_q)
      FUNC_ADD:      simple_res = a_op_a_q + a_op_b_q;
      FUNC_SUB:      simple_res = a_op_a_q - a_op_b_q;
      FUNC_LT:       simple_cmp = a_op_a_q < a_op_b_q;
      FUNC_GT:       simple_cmp = a_op_a_q > a_op_b_q;
      FUNC_LE:       simple_cmp = a_op_a_q <= a_op_b_q;
      FUNC_GE:       simple_cmp = a_op_a_q >= a_op_b_q;
      FUNC_EQ:       simple_cmp = a_op_a_q == a_op_b_q;
      FUNC_NE:       simple_cmp = a_op_a_q != a_op_b_q;
      FUNC_MIN:      simple_res = (a_op_b_q < a_op_a_q) ? a_op_b_q : a_op_a_q;
      FUNC_MAX:      simple_res = (a_op_b_q > a_op_a_q) ? a_op_b_q : a_op_a_q;
      FUNC_INC:      simple_res = a_op_a_q + W'(1);
      FUNC_DEC:      simple_res = a_op_a_q - W'(1);
      FUNC_FROM_INT: simple_res = a_op_a_q << F;
      FUNC_TO_INT:   simple_res = a_op_a_q[W-1] ? W'(-to_int_sh) : to_int_sh;
      default:       simple_res = '0;
    endcase
  end

  logic                  b_valid_q;
  logic                  b_is_mul_q, b_is_div_q, b_dz_q, b_neg_q;
  logic [W-1:0]          b_res_q, b_mag_a_q, b_mag_b_q;
  logic                  b_cmp_q;
  logic signed [2*W-1:0] b_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_is_mul_q <= a_func_q == FUNC_MUL;
    b_is_div_q <= a_func_q == FUNC_DIV;
    b_dz_q     <= (a_func_q == FUNC_DIV) && (a_op_b_q == '0);
    b_neg_q    <= a_op_a_q[W-1] ^ a_op_b_q[W-1];
    b_res_q    <= simple_res;
    b_cmp_q    <= simple_cmp;
    b_mag_a_q  <= mag_a;
    b_mag_b_q  <= mag_b;
    b_prod_q   <= product;
  end

  // stage c: finish the product, feed the divider
  logic [N-1:0] prod_low, prod_mag, prod_sh;
  logic [W-1:0] mul_res, c_res;
  logic [N-1:0] dividend;
  tag_t         div_tag_in;

  always_comb begin
    prod_low = N'(b_prod_q);
    prod_mag = b_prod_q[2*W-1] ? N'(-prod_low) : prod_low;
    prod_sh  = prod_mag >> F;
    mul_res  = b_prod_q[2*W-1] ? W'(-prod_sh[W-1:0]) : prod_sh[W-1:0];
    c_res    = b_is_mul_q ? mul_res : b_res_q;
    dividend = N'(b_mag_a_q) << F;
    div_tag_in.res    = 32'(signed'(c_res));
    div_tag_in.cmp    = b_cmp_q;
    div_tag_in.dz     = b_dz_q;
    div_tag_in.is_div = b_is_div_q;
    div_tag_in.neg    = b_neg_q;
  end

  logic         d_valid;
  logic [N-1:0] d_quo;
  tag_t         d_tag;

  fxalu_divider #(
    .DVD_BITS(N),
    .DVS_BITS(W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (b_valid_q),
    .dividend_i (dividend),
    .divisor_i  (b_mag_b_q),
    .tag_i      (div_tag_in),
    .valid_o    (d_valid),
    .quotient_o (d_quo),
    .tag_o      (d_tag)
  );

  // output stage
  logic [W-1:0] quo_signed;
  rsp_t         rsp_d;

  always_comb begin
    quo_signed = d_tag.neg ? W'(-d_quo[W-1:0]) : d_quo[W-1:0];
    rsp_d.compare_true   = d_tag.cmp;
    rsp_d.divide_by_zero = d_tag.dz;
    if (d_tag.is_div) begin
      rsp_d.result = d_tag.dz ? '0 : 32'(signed'(quo_signed));
    end else begin
      rsp_d.result = d_tag.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_o <= rsp_d;
  end

  a_dz_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.divide_by_zero |-> rsp_o.result == '0 && !rsp_o.compare_true)
    else $error("divide by zero result not cleared");

  a_cmp_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && rsp_o.compare_true |-> rsp_o.result == '0)
    else $error("comparison carries a nonzero result");

  a_div_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && b_dz_q |-> b_is_div_q && b_mag_b_q == '0)
    else $error("divide by zero flag without zero divisor");

  a_never_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> a_valid_q)
    else $error("transaction lost at input stage");

endmodule
`default_nettype wire
